@@ rtl/rktt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rktt_pkg: shared types and constants of the key tag table
// Item field widths, stream packing widths, opcodes and the store control
// bundle passed from the sequencer to the entry store.
// ----------------------------------------------------------------------------
package rktt_pkg;

    // external field widths of one item
    localparam int OPCODE_W    = 3;
    localparam int EXT_KEY_W   = 32;
    localparam int EXT_TAG_W   = 6;
    localparam int COUNT_OUT_W = 7;

    // stream packing
    localparam int S_TDATA_W = 40;  // key, tag, padding
    localparam int S_TUSER_W = 4;   // opcode, tag_valid
    localparam int M_TDATA_W = 48;  // result_tag, result_key, allocated_count, padding
    localparam int M_TUSER_W = 2;   // result_tag_valid, underflow

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_ACQUIRE  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FIND     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_READ_KEY = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd4;

    // store control from the sequencer
    typedef struct packed {
        logic rd_en;      // read key, count and valid bit at rd_addr
        logic key_wr_en;  // write key at wr_addr
        logic cnt_wr_en;  // write count at wr_addr
        logic set_valid;  // mark entry at wr_addr in use
        logic clr_valid;  // mark entry at wr_addr free
        logic clr_all;    // free every entry
    } store_ctrl_t;

endpackage : rktt_pkg
`default_nettype wire

@@ rtl/rktt_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rktt_store: entry store of the key tag table
// Key and count memories with one registered read port and one write port,
// plus a flip-flop valid bit per entry that reset and clear drop at once.
// ----------------------------------------------------------------------------
module rktt_store #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16,
    parameter int IDX_W       = 6
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  rktt_pkg::store_ctrl_t     ctrl,
    input  wire  [IDX_W-1:0]          rd_addr,
    input  wire  [IDX_W-1:0]          wr_addr,
    input  wire  [KEY_WIDTH-1:0]      wr_key,
    input  wire  [COUNT_WIDTH-1:0]    wr_cnt,
    output logic [KEY_WIDTH-1:0]      rd_key,
    output logic [COUNT_WIDTH-1:0]    rd_cnt,
    output logic                      rd_valid
);
    import rktt_pkg::*;

    logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [KEY_WIDTH-1:0]   rd_key_reg;
    logic [COUNT_WIDTH-1:0] rd_cnt_reg;
    logic                   rd_valid_reg;

    // memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (ctrl.key_wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (ctrl.cnt_wr_en)
        begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (ctrl.rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_cnt_reg <= cnt_mem[rd_addr];
        end
    end

    // valid bits: an entry not valid counts as empty with count zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clr_all)
            begin
                vld_reg <= '0;
            end
            else if (ctrl.set_valid)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            else if (ctrl.clr_valid)
            begin
                vld_reg[wr_addr] <= 1'b0;
            end
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_key   = rd_key_reg;
    assign rd_cnt   = rd_cnt_reg;
    assign rd_valid = rd_valid_reg;

endmodule : rktt_store
`default_nettype wire

@@ rtl/rktt_match.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rktt_match: shared key compare unit
// Takes one entry per step during a scan, remembers the first entry that
// holds the probe key (with its count) and the first free entry.
// ----------------------------------------------------------------------------
module rktt_match #(
    parameter int KEY_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16,
    parameter int IDX_W       = 6
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire                       step,
    input  wire  [IDX_W-1:0]          step_idx,
    input  wire                       entry_valid,
    input  wire  [KEY_WIDTH-1:0]      entry_key,
    input  wire  [COUNT_WIDTH-1:0]    entry_cnt,
    input  wire  [KEY_WIDTH-1:0]      probe_key,
    output logic                      hit,
    output logic [IDX_W-1:0]          hit_idx,
    output logic [COUNT_WIDTH-1:0]    hit_cnt,
    output logic                      free_found,
    output logic [IDX_W-1:0]          free_idx
);
    import rktt_pkg::*;

    logic                   hit_reg;
    logic                   free_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [COUNT_WIDTH-1:0] hit_cnt_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic                   key_eq;
    logic                   take_hit;
    logic                   take_free;

    // the one comparator
    assign key_eq    = (entry_key == probe_key);
    assign take_hit  = step && entry_valid && key_eq && !hit_reg;
    assign take_free = step && !entry_valid && !free_reg;

    // first-hit and first-free flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (start)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            if (take_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (take_free)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    // captured positions
    always_ff @(posedge clk)
    begin
        if (take_hit)
        begin
            hit_idx_reg <= step_idx;
            hit_cnt_reg <= entry_cnt;
        end
        if (take_free)
        begin
            free_idx_reg <= step_idx;
        end
    end

    assign hit        = hit_reg;
    assign hit_idx    = hit_idx_reg;
    assign hit_cnt    = hit_cnt_reg;
    assign free_found = free_reg;
    assign free_idx   = free_idx_reg;

endmodule : rktt_match
`default_nettype wire

@@ rtl/refcounted_key_tag_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequence: acquire and find with a nonzero key scan every entry, then drain and
//   finish; release and read key with a valid tag read the entry, then finish;
//   the rest go straight to finish. The unit returns to idle between items.
// Throughput: one item at a time, set by the scan of one entry per cycle
//   through the single read port of the key memory.
// Reset: rst_n (asynchronous, active low) empties the table at once.
// ----------------------------------------------------------------------------
// refcounted_key_tag_table_unit: reference counted key to tag table
// Maps nonzero keys to tags with a count per entry; acquire, release, find,
// read key and clear, one result item per input item.
// ----------------------------------------------------------------------------
module refcounted_key_tag_table_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [rktt_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // key[31:0], tag[37:32], pad
    input  wire  [rktt_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // opcode[2:0], tag_valid[3]
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [rktt_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // result_tag[5:0],
                                                            // result_key[37:6],
                                                            // allocated_count[44:38], pad
    output logic [rktt_pkg::M_TUSER_W-1:0]   m_axis_tuser   // result_tag_valid[0],
                                                            // underflow[1]
);
    import rktt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_READ   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    // item fields
    logic [OPCODE_W-1:0]  in_opcode;
    logic [EXT_KEY_W-1:0] in_key;
    logic [EXT_TAG_W-1:0] in_tag;
    logic                 in_tag_valid;
    logic [KEY_WIDTH-1:0] in_key_m;
    logic                 in_tag_ok;
    logic                 in_accept;

    assign in_key       = s_axis_tdata[EXT_KEY_W-1:0];
    assign in_tag       = s_axis_tdata[EXT_KEY_W +: EXT_TAG_W];
    assign in_opcode    = s_axis_tuser[OPCODE_W-1:0];
    assign in_tag_valid = s_axis_tuser[OPCODE_W];
    assign in_key_m     = KEY_WIDTH'(in_key);
    assign in_tag_ok    = in_tag_valid && (32'(in_tag) < TABLE_DEPTH);

    state_t               state_reg, state_next;
    logic [OPCODE_W-1:0]  op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [IDX_W-1:0]     tag_reg, tag_next;
    logic                 tag_ok_reg, tag_ok_next;
    logic                 keynz_reg, keynz_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 step_vld_reg, step_vld_next;
    logic [IDX_W-1:0]     step_idx_reg, step_idx_next;
    logic [USED_W-1:0]    used_reg, used_next;

    // output register
    logic                   m_vld_reg, m_vld_next;
    logic [EXT_TAG_W-1:0]   res_tag_reg, res_tag_next;
    logic                   res_tvld_reg, res_tvld_next;
    logic [EXT_KEY_W-1:0]   res_key_reg, res_key_next;
    logic [COUNT_OUT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                   res_under_reg, res_under_next;
    logic                   out_free;
    logic                   load_out;

    // store and compare unit wiring
    store_ctrl_t            st_ctrl;
    logic [IDX_W-1:0]       st_rd_addr;
    logic [IDX_W-1:0]       st_wr_addr;
    logic [KEY_WIDTH-1:0]   st_wr_key;
    logic [COUNT_WIDTH-1:0] st_wr_cnt;
    logic [KEY_WIDTH-1:0]   st_rd_key;
    logic [COUNT_WIDTH-1:0] st_rd_cnt;
    logic                   st_rd_valid;
    logic                   m_start;
    logic                   m_hit;
    logic [IDX_W-1:0]       m_hit_idx;
    logic [COUNT_WIDTH-1:0] m_hit_cnt;
    logic                   m_free;
    logic [IDX_W-1:0]       m_free_idx;

    rktt_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (st_ctrl),
        .rd_addr  (st_rd_addr),
        .wr_addr  (st_wr_addr),
        .wr_key   (st_wr_key),
        .wr_cnt   (st_wr_cnt),
        .rd_key   (st_rd_key),
        .rd_cnt   (st_rd_cnt),
        .rd_valid (st_rd_valid)
    );

    rktt_match #(
        .KEY_WIDTH   (KEY_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IDX_W       (IDX_W)
    ) u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (m_start),
        .step        (step_vld_reg),
        .step_idx    (step_idx_reg),
        .entry_valid (st_rd_valid),
        .entry_key   (st_rd_key),
        .entry_cnt   (st_rd_cnt),
        .probe_key   (key_reg),
        .hit         (m_hit),
        .hit_idx     (m_hit_idx),
        .hit_cnt     (m_hit_cnt),
        .free_found  (m_free),
        .free_idx    (m_free_idx)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_vld_reg || m_axis_tready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        tag_next       = tag_reg;
        tag_ok_next    = tag_ok_reg;
        keynz_next     = keynz_reg;
        scan_idx_next  = scan_idx_reg;
        step_vld_next  = (state_reg == ST_SCAN);
        step_idx_next  = scan_idx_reg;
        used_next      = used_reg;
        st_ctrl        = '0;
        st_rd_addr     = scan_idx_reg;
        st_wr_addr     = tag_reg;
        st_wr_key      = key_reg;
        st_wr_cnt      = st_rd_cnt;
        m_start        = 1'b0;
        load_out       = 1'b0;
        res_tag_next   = res_tag_reg;
        res_tvld_next  = res_tvld_reg;
        res_key_next   = res_key_reg;
        res_under_next = res_under_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = in_opcode;
                    key_next    = in_key_m;
                    tag_next    = IDX_W'(in_tag);
                    tag_ok_next = in_tag_ok;
                    keynz_next  = |in_key_m;
                    priority if (((in_opcode == OP_ACQUIRE) || (in_opcode == OP_FIND))
                                 && (|in_key_m))
                    begin
                        m_start       = 1'b1;
                        scan_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                    else if (((in_opcode == OP_RELEASE) || (in_opcode == OP_READ_KEY))
                             && in_tag_ok)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            // one entry read per cycle, compared in the cycle after its read
            ST_SCAN:
            begin
                st_ctrl.rd_en = 1'b1;
                st_rd_addr    = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end

            ST_READ:
            begin
                st_ctrl.rd_en = 1'b1;
                st_rd_addr    = tag_reg;
                state_next    = ST_FINISH;
            end

            // once the output register is free, apply the update and load the result
            ST_FINISH:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    res_tag_next   = '0;
                    res_tvld_next  = 1'b0;
                    res_key_next   = '0;
                    res_under_next = 1'b0;
                    state_next     = ST_IDLE;
                    unique case (op_reg)
                        OP_ACQUIRE:
                        begin
                            if (keynz_reg)
                            begin
                                priority if (m_hit)
                                begin
                                    st_ctrl.cnt_wr_en = 1'b1;
                                    st_wr_addr        = m_hit_idx;
                                    st_wr_cnt         = (&m_hit_cnt) ? m_hit_cnt
                                                                     : m_hit_cnt + 1'b1;
                                    res_tag_next      = EXT_TAG_W'(m_hit_idx);
                                    res_tvld_next     = 1'b1;
                                end
                                else if (m_free)
                                begin
                                    st_ctrl.key_wr_en = 1'b1;
                                    st_ctrl.cnt_wr_en = 1'b1;
                                    st_ctrl.set_valid = 1'b1;
                                    st_wr_addr        = m_free_idx;
                                    st_wr_key         = key_reg;
                                    st_wr_cnt         = COUNT_WIDTH'(1);
                                    used_next         = used_reg + 1'b1;
                                    res_tag_next      = EXT_TAG_W'(m_free_idx);
                                    res_tvld_next     = 1'b1;
                                end
                                else
                                begin
                                    res_tvld_next = 1'b0;
                                end
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (tag_ok_reg)
                            begin
                                if (!st_rd_valid)
                                begin
                                    res_under_next = 1'b1;
                                end
                                else
                                begin
                                    st_ctrl.cnt_wr_en = 1'b1;
                                    st_wr_addr        = tag_reg;
                                    st_wr_cnt         = st_rd_cnt - 1'b1;
                                    if (st_rd_cnt == COUNT_WIDTH'(1))
                                    begin
                                        st_ctrl.clr_valid = 1'b1;
                                        if (used_reg != '0)
                                        begin
                                            used_next = used_reg - 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        OP_FIND:
                        begin
                            if (keynz_reg && m_hit)
                            begin
                                res_tag_next  = EXT_TAG_W'(m_hit_idx);
                                res_tvld_next = 1'b1;
                            end
                        end
                        OP_READ_KEY:
                        begin
                            if (tag_ok_reg && st_rd_valid)
                            begin
                                res_key_next = EXT_KEY_W'(st_rd_key);
                            end
                        end
                        OP_CLEAR:
                        begin
                            st_ctrl.clr_all = 1'b1;
                            used_next       = '0;
                        end
                        default:
                        begin
                            res_tvld_next = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_cnt_next = COUNT_OUT_W'(used_next);
    assign m_vld_next   = load_out ? 1'b1 : (m_axis_tready ? 1'b0 : m_vld_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            m_vld_reg    <= 1'b0;
            step_vld_reg <= 1'b0;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            m_vld_reg    <= m_vld_next;
            step_vld_reg <= step_vld_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    // operand and result payload
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        tag_reg      <= tag_next;
        tag_ok_reg   <= tag_ok_next;
        keynz_reg    <= keynz_next;
        step_idx_reg <= step_idx_next;
        if (load_out)
        begin
            res_tag_reg   <= res_tag_next;
            res_tvld_reg  <= res_tvld_next;
            res_key_reg   <= res_key_next;
            res_cnt_reg   <= res_cnt_next;
            res_under_reg <= res_under_next;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = {
        (M_TDATA_W - EXT_TAG_W - EXT_KEY_W - COUNT_OUT_W)'(0),
        res_cnt_reg, res_key_reg, res_tag_reg
    };
    assign m_axis_tuser  = {res_under_reg, res_tvld_reg};

endmodule : refcounted_key_tag_table_unit
`default_nettype wire

@@ sim/tb_refcounted_key_tag_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_key_tag_table_unit: self-checking bench of the key tag table
// Feeds acquire, release, find, read key, clear and unused-opcode items over
// the input stream, predicts each result item from a private model of the
// table and compares it field by field with what the output stream returns.
// ----------------------------------------------------------------------------
module tb_refcounted_key_tag_table_unit;

    import rktt_pkg::*;

    localparam int          DEPTH        = 64;
    localparam int          CNT_W        = 16;
    localparam logic [15:0] REFCNT_MAX   = '1;
    localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
    localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
    localparam int          N_ITEMS      = 1720;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          POOL_SIZE    = 16;

    typedef struct {
        logic [OPCODE_W-1:0]  opcode;
        logic [EXT_KEY_W-1:0] key;
        logic [EXT_TAG_W-1:0] tag;
        logic                 tag_valid;
    } table_op_t;

    typedef struct {
        logic [EXT_TAG_W-1:0]   result_tag;
        logic                   result_tag_valid;
        logic [EXT_KEY_W-1:0]   result_key;
        logic [COUNT_OUT_W-1:0] allocated_count;
        logic                   underflow;
    } table_resp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // model of the table contents
    logic [EXT_KEY_W-1:0]   model_key [DEPTH];
    logic [CNT_W-1:0]       model_cnt [DEPTH];
    logic [COUNT_OUT_W-1:0] model_used;

    table_op_t   pending_ops[$];
    table_resp_t expected_resps[$];
    table_op_t   op_in_flight;
    table_resp_t resp_want;

    logic [EXT_KEY_W-1:0] key_pool [POOL_SIZE];
    logic [EXT_KEY_W-1:0] issued_keys[$];

    int n_items   = 0;
    int n_sent    = 0;
    int n_resps   = 0;
    int errors    = 0;
    int quiet_cyc = 0;

    refcounted_key_tag_table_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // key[31:0], tag[37:32], pad
        .s_axis_tuser  (s_axis_tuser),   // opcode[2:0], tag_valid[3]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // result_tag[5:0], result_key[37:6],
                                         // allocated_count[44:38], pad
        .m_axis_tuser  (m_axis_tuser)    // result_tag_valid[0], underflow[1]
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // apply one operation to the model table and return the expected result
    function automatic table_resp_t tag_table_apply(table_op_t op);
        table_resp_t r;
        logic        have_free;
        logic        hit;
        int          free_idx;
        r = '{default: '0};
        have_free = 1'b0;
        hit = 1'b0;
        free_idx = 0;
        case (op.opcode)
            OP_ACQUIRE:
            begin
                if (op.key != '0)
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (!hit)
                        begin
                            if (model_cnt[i] == '0)
                            begin
                                if (!have_free)
                                begin
                                    have_free = 1'b1;
                                    free_idx = i;
                                end
                            end
                            else if (model_key[i] == op.key)
                            begin
                                // count saturates at its maximum
                                if (model_cnt[i] != REFCNT_MAX)
                                    model_cnt[i] = model_cnt[i] + 1'b1;
                                r.result_tag = EXT_TAG_W'(i);
                                r.result_tag_valid = 1'b1;
                                hit = 1'b1;
                            end
                        end
                    end
                    if (!hit && have_free)
                    begin
                        model_key[free_idx] = op.key;
                        model_cnt[free_idx] = CNT_W'(1);
                        model_used = model_used + 1'b1;
                        r.result_tag = EXT_TAG_W'(free_idx);
                        r.result_tag_valid = 1'b1;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (op.tag_valid)
                begin
                    if (model_cnt[op.tag] == '0)
                        r.underflow = 1'b1;
                    else
                    begin
                        model_cnt[op.tag] = model_cnt[op.tag] - 1'b1;
                        if (model_cnt[op.tag] == '0)
                        begin
                            model_key[op.tag] = '0;
                            if (model_used != '0)
                                model_used = model_used - 1'b1;
                        end
                    end
                end
            end
            OP_FIND:
            begin
                if (op.key != '0)
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (!hit && model_cnt[i] != '0 && model_key[i] == op.key)
                        begin
                            r.result_tag = EXT_TAG_W'(i);
                            r.result_tag_valid = 1'b1;
                            hit = 1'b1;
                        end
                    end
                end
            end
            OP_READ_KEY:
            begin
                if (op.tag_valid)
                    r.result_key = model_key[op.tag];
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    model_key[i] = '0;
                    model_cnt[i] = '0;
                end
                model_used = '0;
            end
            default:
            begin
            end
        endcase
        r.allocated_count = model_used;
        return r;
    endfunction

    function automatic void queue_op(logic [2:0] opc, logic [31:0] key,
                                     logic [5:0] tag, logic tv);
        table_op_t op;
        op.opcode = opc;
        op.key = key;
        op.tag = tag;
        op.tag_valid = tv;
        pending_ops.push_back(op);
    endfunction

    // key choice for acquire and find: mostly recurring keys, some fresh, a few empty
    function automatic logic [31:0] pick_key();
        int          r;
        logic [31:0] k;
        r = $urandom_range(0, 99);
        if (r < 5)
            k = '0;
        else if (r < 60 || issued_keys.size() == 0)
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 90)
            k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
        else
        begin
            k = $urandom();
            issued_keys.push_back(k);
        end
        return k;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // stimulus build, reset and end of run
    initial
    begin : stim_main
        int r;
        int seg;
        for (int i = 0; i < DEPTH; i++)
        begin
            model_key[i] = '0;
            model_cnt[i] = '0;
        end
        model_used = '0;
        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'h0000_0001;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        // directed: empty keys, extremes, misses, ignored and underflowing releases
        queue_op(OP_ACQUIRE, 32'h0, 6'd0, 1'b1);
        queue_op(OP_FIND, 32'h0, 6'd0, 1'b1);
        queue_op(OP_ACQUIRE, 32'hFFFF_FFFF, 6'd63, 1'b0);
        queue_op(OP_ACQUIRE, 32'h0000_0001, 6'd0, 1'b0);
        queue_op(OP_ACQUIRE, 32'hFFFF_FFFF, 6'd0, 1'b1);
        queue_op(OP_FIND, 32'hFFFF_FFFF, 6'd63, 1'b1);
        queue_op(OP_FIND, 32'h1234_5678, 6'd0, 1'b0);
        queue_op(OP_READ_KEY, 32'h0, 6'd0, 1'b1);
        queue_op(OP_READ_KEY, 32'hFFFF_FFFF, 6'd1, 1'b0);
        queue_op(OP_READ_KEY, 32'h0, 6'd63, 1'b1);
        queue_op(OP_RELEASE, 32'h0, 6'd1, 1'b0);
        queue_op(OP_RELEASE, 32'hFFFF_FFFF, 6'd1, 1'b1);
        queue_op(OP_RELEASE, 32'h0, 6'd1, 1'b1);
        queue_op(OP_RELEASE, 32'h0, 6'd63, 1'b1);
        queue_op(OP_ACQUIRE, 32'h8000_0000, 6'd0, 1'b1);
        for (logic [3:0] u = 4'(OP_UNUSED_LO); u <= 4'(OP_UNUSED_HI); u++)
            queue_op(u[2:0], $urandom(), 6'($urandom()), 1'($urandom()));
        queue_op(OP_CLEAR, 32'hFFFF_FFFF, 6'd63, 1'b1);
        queue_op(OP_READ_KEY, 32'h0, 6'd0, 1'b1);
        queue_op(OP_RELEASE, 32'h0, 6'd0, 1'b1);

        // random segments: filling bursts run into a full table, release bursts
        // free entries again, mixed traffic works on a recurring set of keys
        while (pending_ops.size() < N_ITEMS)
        begin
            seg = $urandom_range(0, 9);
            if (seg < 2)
            begin
                for (int i = 0; i < DEPTH + 2; i++)
                begin
                    issued_keys.push_back($urandom());
                    queue_op(OP_ACQUIRE, issued_keys[$], 6'($urandom()), 1'($urandom()));
                end
            end
            else if (seg < 3)
            begin
                for (int i = 0; i < 40; i++)
                    queue_op(OP_RELEASE, $urandom(), 6'($urandom()),
                             $urandom_range(0, 9) != 0);
            end
            else
            begin
                for (int i = 0; i < 40; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 35)
                        queue_op(OP_ACQUIRE, pick_key(), 6'($urandom()), 1'($urandom()));
                    else if (r < 65)
                        queue_op(OP_RELEASE, $urandom(), 6'($urandom()),
                                 $urandom_range(0, 9) != 0);
                    else if (r < 80)
                        queue_op(OP_FIND, pick_key(), 6'($urandom()), 1'($urandom()));
                    else if (r < 93)
                        queue_op(OP_READ_KEY, $urandom(), 6'($urandom()),
                                 $urandom_range(0, 9) != 0);
                    else if (r < 95)
                        queue_op(OP_CLEAR, $urandom(), 6'($urandom()), 1'($urandom()));
                    else
                        queue_op(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                                 $urandom(), 6'($urandom()), 1'($urandom()));
                end
            end
        end
        n_items = pending_ops.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_sent == n_items && !s_axis_tvalid && expected_resps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // input driver: holds an item until accepted, idles between items at random
    always @(posedge clk or negedge rst_n)
    begin : op_driver
        logic drive_next;
        int   idle_pct;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            drive_next = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_resps.push_back(tag_table_apply(op_in_flight));
                drive_next = 1'b0;
            end
            case ((n_sent * 3) / (n_items > 0 ? n_items : 1))
                0: idle_pct = 19;
                1: idle_pct = 55;
                default: idle_pct = 0;
            endcase
            if (!drive_next && pending_ops.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct)
            begin
                op_in_flight = pending_ops.pop_front();
                s_axis_tdata <= {2'b00, op_in_flight.tag, op_in_flight.key};
                s_axis_tuser <= {op_in_flight.tag_valid, op_in_flight.opcode};
                drive_next = 1'b1;
                n_sent++;
            end
            s_axis_tvalid <= drive_next;
        end
    end

    // result monitor: compares each accepted result item with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : resp_monitor
        int stall_pct;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_resps.size() == 0)
                begin
                    $error("result item with no prediction waiting");
                    errors++;
                end
                else
                begin
                    resp_want = expected_resps.pop_front();
                    check_field("result_tag", 32'(resp_want.result_tag),
                                32'(m_axis_tdata[5:0]));
                    check_field("result_key", resp_want.result_key, m_axis_tdata[37:6]);
                    check_field("allocated_count", 32'(resp_want.allocated_count),
                                32'(m_axis_tdata[44:38]));
                    check_field("result_tag_valid", 32'(resp_want.result_tag_valid),
                                32'(m_axis_tuser[0]));
                    check_field("underflow", 32'(resp_want.underflow),
                                32'(m_axis_tuser[1]));
                end
                n_resps++;
            end
            case ((n_resps * 3) / (n_items > 0 ? n_items : 1))
                0: stall_pct = 55;
                1: stall_pct = 19;
                default: stall_pct = 0;
            endcase
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cyc <= 0;
        else if (quiet_cyc >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cyc <= quiet_cyc + 1;
    end

endmodule
